// ===== rtl/core/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg: shared constants and types for the page run allocator
// Sizes, status codes and action codes.
// ----------------------------------------------------------------------------
package pra_pkg;
	localparam int TABLE_ENTRIES_DEF   = 512;
	localparam int DIR_ENTRIES_DEF     = 4;
	localparam int STACK_DEPTH_DEF     = 1024;
	localparam int RESERVED_FRAMES_DEF = 512;
	localparam int PAGE_SHIFT          = 12;
	localparam int FRAME_W             = 20;
	localparam int ENTRY_W             = 21;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_TAKE   = 2'd1,
		ACT_RETURN = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NO_RUN  = 3'd1,
		ST_NO_FRM  = 3'd2,
		ST_FULL    = 3'd3,
		ST_BAD_LEN = 3'd4
	} status_t;
endpackage

// ===== rtl/core/page_run_allocator_with_frame_stack_unit.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_with_frame_stack_unit
// Frame stack plus two-level page table with a first-fit run scanner.
// ----------------------------------------------------------------------------
// channel | signals                                   | handshake
// command | start, action, run_length, frame_number   | start && !busy
// result  | done, status, address                     | done, one cycle
//
// take_frame: busy in S_POP_RD and S_POP after accept; done is registered in S_POP.
// return_frame, zero length and unknown actions: done the cycle after accept.
// alloc_run: one page-entry read per cycle for the scan, then one directory
// per cycle up to the run's end to count absent ones, then S_DIR and an
// S_WIPE of all TABLE_ENTRIES entries to map and clear each absent directory,
// and S_MAP_RD and S_MAP for each run entry.
// After reset a clearing pass writes every page entry and stack entry, one a
// cycle; busy is high.
// The receiver cannot stall: done pulses once per command.
module page_run_allocator_with_frame_stack_unit
	import pra_pkg::*;
#(
	parameter int TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
	parameter int DIR_ENTRIES     = DIR_ENTRIES_DEF,
	parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
	parameter int RESERVED_FRAMES = RESERVED_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  action,
	input  logic [11:0] run_length,
	input  logic [19:0] frame_number,
	output logic        busy,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] address
);
	localparam int TOTAL = DIR_ENTRIES * TABLE_ENTRIES;
	localparam int IW    = $clog2(TOTAL + 1);
	localparam int PW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int TW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int DW    = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
	localparam int SW    = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CW    = (IW > SW) ? IW : SW;
	localparam int NW    = ((SW > 12) ? SW : 12) + 2;
	localparam int CLR_N = (TOTAL > STACK_DEPTH) ? TOTAL : STACK_DEPTH;
	localparam int SP0   = (RESERVED_FRAMES > STACK_DEPTH) ? STACK_DEPTH
	                                                       : RESERVED_FRAMES;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN, S_CHECK, S_DIR_RD, S_DIR,
		S_WIPE, S_MAP_RD, S_MAP, S_POP_RD, S_POP
	} state_t;

	state_t           state_q;
	logic [ENTRY_W-1:0] page_mem [TOTAL];
	logic [FRAME_W-1:0] stack_mem [STACK_DEPTH];
	logic [ENTRY_W-1:0] pg_rd_q;
	logic [FRAME_W-1:0] st_rd_q;
	logic [DIR_ENTRIES-1:0] dir_pres_q;
	logic [FRAME_W-1:0] dir_frm_q [DIR_ENTRIES];
	logic [SW-1:0]    sp_q;
	logic [CW-1:0]    clr_q;
	logic [IW-1:0]    idx_q, cnt_q, end_q, first_q, wipe_q;
	logic [11:0]      len_q;
	logic [DW:0]      dir_q, last_q;
	logic [DW:0]      absent_q;
	// directory and table offset of the entry held in pg_rd_q
	logic [DW-1:0]    sdir_q;
	logic [TW-1:0]    stab_q;

	// shared index adder / compare unit
	logic [IW-1:0]    idx_nx;
	logic [IW-1:0]    cnt_nx;
	logic             used;
	logic [DW-1:0]    idx_dir;
	assign idx_nx  = idx_q + IW'(1);
	assign idx_dir = sdir_q;
	assign used    = dir_pres_q[idx_dir] && pg_rd_q[0];
	assign cnt_nx  = used ? '0 : cnt_q + IW'(1);
	assign busy    = (state_q != S_IDLE);

	logic [NW-1:0] avail, need;
	assign avail = NW'(STACK_DEPTH) - NW'(sp_q);
	assign need  = NW'(absent_q) + NW'(len_q);

	logic [DW:0] dir_nx;
	assign dir_nx = dir_q + (DW+1)'(1);

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			if (clr_q < CW'(TOTAL)) page_mem[clr_q[PW-1:0]] <= '0;
			if (clr_q < CW'(STACK_DEPTH))
				stack_mem[clr_q[AW-1:0]] <= FRAME_W'(clr_q);
		end else if (state_q == S_IDLE && start && action == ACT_RETURN && sp_q != '0) begin
			stack_mem[AW'(sp_q - SW'(1))] <= frame_number;
		end else if (state_q == S_WIPE) begin
			page_mem[wipe_q[PW-1:0]] <= '0;
		end else if (state_q == S_MAP) begin
			page_mem[idx_q[PW-1:0]] <= {st_rd_q, 1'b1};
		end
		pg_rd_q <= page_mem[(idx_q < IW'(TOTAL)) ? idx_q[PW-1:0] : '0];
		st_rd_q <= stack_mem[sp_q[AW-1:0] & AW'(STACK_DEPTH > 0 ? -1 : 0)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			sp_q       <= SW'(SP0);
			dir_pres_q <= '0;
			done       <= 1'b0;
			status     <= '0;
			address    <= '0;
			idx_q <= '0; cnt_q <= '0; end_q <= '0; first_q <= '0; wipe_q <= '0;
			len_q <= '0; dir_q <= '0; last_q <= '0; absent_q <= '0;
			sdir_q <= '0; stab_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
			S_CLEAR: begin
				clr_q <= clr_q + CW'(1);
				if (clr_q == CW'(CLR_N - 1)) state_q <= S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					address <= '0;
					status  <= ST_OK;
					case (action_t'(action))
					ACT_ALLOC: begin
						len_q  <= run_length;
						idx_q  <= '0;
						cnt_q  <= '0;
						sdir_q <= '0;
						stab_q <= '0;
						if (run_length == '0) begin
							status <= ST_BAD_LEN; done <= 1'b1;
						end else state_q <= S_SCAN_RD;
					end
					ACT_TAKE: begin
						if (sp_q >= SW'(STACK_DEPTH)) begin
							status <= ST_NO_FRM; done <= 1'b1;
						end else state_q <= S_POP_RD;
					end
					ACT_RETURN: begin
						if (sp_q == '0) status <= ST_FULL;
						else sp_q <= sp_q - SW'(1);
						done <= 1'b1;
					end
					default: done <= 1'b1;
					endcase
				end
			end
			S_POP_RD: state_q <= S_POP;
			S_POP: begin
				address <= {st_rd_q, 12'd0};
				sp_q    <= sp_q + SW'(1);
				done    <= 1'b1;
				state_q <= S_IDLE;
			end
			S_SCAN_RD: begin
				// memory read of idx_q lands next cycle
				idx_q   <= idx_nx;
				state_q <= S_SCAN;
			end
			S_SCAN: begin
				// pg_rd_q holds entry idx_q-1
				cnt_q <= cnt_nx;
				if (!used && 32'(cnt_nx) == 32'(len_q)) begin
					end_q    <= idx_q - IW'(1);
					first_q  <= idx_q - IW'(len_q);
					last_q   <= (DW+1)'(idx_dir);
					dir_q    <= '0;
					absent_q <= '0;
					state_q  <= S_CHECK;
				end else if (idx_q == IW'(TOTAL)) begin
					status <= ST_NO_RUN; done <= 1'b1; state_q <= S_IDLE;
				end else begin
					idx_q <= idx_nx;
					// advance the directory at each table boundary
					if (stab_q == TW'(TABLE_ENTRIES - 1)) begin
						stab_q <= '0;
						sdir_q <= sdir_q + DW'(1);
					end else stab_q <= stab_q + TW'(1);
				end
			end
			S_CHECK: begin
				// count absent directories one per cycle
				if (!dir_pres_q[dir_q[DW-1:0]]) absent_q <= absent_q + (DW+1)'(1);
				if (dir_q == last_q) begin
					dir_q   <= '0;
					state_q <= S_DIR_RD;
				end else dir_q <= dir_nx;
			end
			S_DIR_RD: begin
				if (dir_q == '0 && avail < need) begin
					status <= ST_NO_FRM; done <= 1'b1; state_q <= S_IDLE;
				end else if (dir_q > last_q) begin
					idx_q <= first_q; state_q <= S_MAP_RD;
				end else if (dir_pres_q[dir_q[DW-1:0]]) begin
					dir_q <= dir_nx;
				end else state_q <= S_DIR;
				absent_q <= '0;
			end
			S_DIR: begin
				dir_pres_q[dir_q[DW-1:0]] <= 1'b1;
				dir_frm_q[dir_q[DW-1:0]]  <= st_rd_q;
				sp_q    <= sp_q + SW'(1);
				wipe_q  <= IW'(dir_q[DW-1:0] * TABLE_ENTRIES);
				idx_q   <= '0;
				state_q <= S_WIPE;
			end
			S_WIPE: begin
				wipe_q <= wipe_q + IW'(1);
				idx_q  <= idx_nx;
				if (idx_q == IW'(TABLE_ENTRIES - 1)) begin
					dir_q <= dir_nx; state_q <= S_DIR_RD;
				end
			end
			S_MAP_RD: state_q <= S_MAP;
			S_MAP: begin
				sp_q <= sp_q + SW'(1);
				if (idx_q == end_q) begin
					address <= 32'(first_q) << PAGE_SHIFT;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end else begin
					idx_q <= idx_nx; state_q <= S_MAP_RD;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/pra_checker.sv =====
// ----------------------------------------------------------------------------
// pra_checker: port-level checks on the allocator
// ----------------------------------------------------------------------------
module pra_checker
	import pra_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic [1:0]  action,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] address
);
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= 3'(ST_BAD_LEN)) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != 3'(ST_OK) |-> address == '0) else $error("addr on error");
	a_page_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> address[11:0] == '0) else $error("unaligned");
	a_ret_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == 2'(ACT_RETURN) |=> done) else $error("return lost");
endmodule

bind page_run_allocator_with_frame_stack_unit pra_checker u_pra_checker (.*);
